// ===== hdl/array_deque_engine_defines.svh =====
// Assertion macros for the array deque engine
`ifndef ARRAY_DEQUE_ENGINE_DEFINES_SVH
`define ARRAY_DEQUE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ADE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("array_deque_engine assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ADE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("array_deque_engine assertion failed");

`endif

// ===== hdl/ade_pkg.sv =====
// Types, codes and microprogram for the array deque engine
package ade_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  // request modes
  localparam logic [2:0] MODE_PUSHF = 3'd0;
  localparam logic [2:0] MODE_PUSHB = 3'd1;
  localparam logic [2:0] MODE_LIST  = 3'd2;
  localparam logic [2:0] MODE_POPF  = 3'd3;
  localparam logic [2:0] MODE_POPB  = 3'd4;

  // result status
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_value;
    logic               last_of_run;
  } out_item_t;

  // datapath operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_PUSHF = 3'd1;
  localparam logic [2:0] OP_PUSHB = 3'd2;
  localparam logic [2:0] OP_LDPTR = 3'd3;
  localparam logic [2:0] OP_LIST  = 3'd4;
  localparam logic [2:0] OP_POPF  = 3'd5;
  localparam logic [2:0] OP_POPB  = 3'd6;
  localparam logic [2:0] OP_EMPTY = 3'd7;

  // store read address select
  localparam logic [1:0] RS_HEAD = 2'd0;
  localparam logic [1:0] RS_TAIL = 2'd1;
  localparam logic [1:0] RS_PTR  = 2'd2;

  // jump conditions
  localparam logic [1:0] CND_ALWAYS   = 2'd0;
  localparam logic [1:0] CND_EMPTY    = 2'd1;
  localparam logic [1:0] CND_AT_TAIL  = 2'd2;
  localparam logic [1:0] CND_DISPATCH = 2'd3;

  // step addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] UPC_PUSHF = 4'd1;
  localparam logic [UPC_W-1:0] UPC_PUSHB = 4'd2;
  localparam logic [UPC_W-1:0] UPC_LIST  = 4'd3;
  localparam logic [UPC_W-1:0] UPC_LISTE = 4'd4;
  localparam logic [UPC_W-1:0] UPC_POPF  = 4'd5;
  localparam logic [UPC_W-1:0] UPC_POPFX = 4'd6;
  localparam logic [UPC_W-1:0] UPC_POPB  = 4'd7;
  localparam logic [UPC_W-1:0] UPC_POPBX = 4'd8;
  localparam logic [UPC_W-1:0] UPC_EMPTY = 4'd9;

  typedef struct packed {
    logic [2:0]       op;
    logic             emit;
    logic [1:0]       rsel;
    logic [1:0]       cond;
    logic [UPC_W-1:0] tgt_t;
    logic [UPC_W-1:0] tgt_f;
  } ucw_t;

  function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
    ucw_t w;
    w = '{op: OP_NOP, emit: 1'b0, rsel: RS_HEAD, cond: CND_ALWAYS,
          tgt_t: UPC_IDLE, tgt_f: UPC_IDLE};
    case (upc)
      UPC_IDLE:  w.cond = CND_DISPATCH;
      UPC_PUSHF: begin w.op = OP_PUSHF; w.emit = 1'b1; end
      UPC_PUSHB: begin w.op = OP_PUSHB; w.emit = 1'b1; end
      UPC_LIST: begin
        w.op = OP_LDPTR; w.rsel = RS_PTR; w.cond = CND_EMPTY;
        w.tgt_t = UPC_EMPTY; w.tgt_f = UPC_LISTE;
      end
      UPC_LISTE: begin
        w.op = OP_LIST; w.emit = 1'b1; w.rsel = RS_PTR; w.cond = CND_AT_TAIL;
        w.tgt_t = UPC_IDLE; w.tgt_f = UPC_LISTE;
      end
      UPC_POPF: begin
        w.rsel = RS_HEAD; w.cond = CND_EMPTY;
        w.tgt_t = UPC_EMPTY; w.tgt_f = UPC_POPFX;
      end
      UPC_POPFX: begin w.op = OP_POPF; w.emit = 1'b1; end
      UPC_POPB: begin
        w.rsel = RS_TAIL; w.cond = CND_EMPTY;
        w.tgt_t = UPC_EMPTY; w.tgt_f = UPC_POPBX;
      end
      // keep reading the tail while the result waits
      UPC_POPBX: begin w.op = OP_POPB; w.emit = 1'b1; w.rsel = RS_TAIL; end
      UPC_EMPTY: begin w.op = OP_EMPTY; w.emit = 1'b1; end
      default: ;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/array_deque_engine.sv =====
// Array deque engine: microcoded sequencer over a fixed element array
// Requests are taken one at a time: in_stall is high while the microprogram is away from idle.
// A push emits its result from its PUSHF or PUSHB step. A pop or a list first tests for an
// empty queue and then emits an empty-queue report, or the popped entry, or one result per
// stored element of a list. An unknown mode returns to idle with no result. An output stall
// holds the emitting step. Reset: synchronous, active low; queue empty, indexes zero, idle.
`include "array_deque_engine_defines.svh"

module array_deque_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ade_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ade_pkg::out_item_t out_data
);

  logic [ade_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic [ade_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [ade_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [ade_pkg::IDX_W-1:0] ptr_r, ptr_nxt;
  logic                      empty_r, empty_nxt;
  logic signed [31:0]        val_r;
  logic signed [31:0]        rd_data_r;
  logic signed [31:0]        store_r [ade_pkg::DEPTH];
  logic                      out_valid_r, out_valid_nxt;
  ade_pkg::out_item_t        out_data_r;
  ade_pkg::out_item_t        res;
  ade_pkg::ucw_t             uw;
  logic                      accept;
  logic                      out_free;
  logic                      go;
  logic                      at_tail;
  logic                      full_f, full_b;
  logic                      wr_en;
  logic [ade_pkg::IDX_W-1:0] wr_addr;
  logic [ade_pkg::IDX_W-1:0] rd_addr;
  logic                      cond_hit;

  assign uw       = ade_pkg::ucode(upc_r);
  assign in_stall = (upc_r != ade_pkg::UPC_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // hold the step while its result cannot be loaded
  assign go       = !uw.emit || out_free;
  assign at_tail  = (ptr_r == tail_r);
  assign full_f   = !empty_r && (head_r == '0);
  assign full_b   = !empty_r && (tail_r == ade_pkg::IDX_LAST);

  always_comb begin
    case (uw.cond)
      ade_pkg::CND_EMPTY:   cond_hit = empty_r;
      ade_pkg::CND_AT_TAIL: cond_hit = at_tail;
      default:              cond_hit = 1'b1;
    endcase
    upc_nxt = upc_r;
    if (uw.cond == ade_pkg::CND_DISPATCH) begin
      if (accept) begin
        case (in_data.mode)
          ade_pkg::MODE_PUSHF: upc_nxt = ade_pkg::UPC_PUSHF;
          ade_pkg::MODE_PUSHB: upc_nxt = ade_pkg::UPC_PUSHB;
          ade_pkg::MODE_LIST:  upc_nxt = ade_pkg::UPC_LIST;
          ade_pkg::MODE_POPF:  upc_nxt = ade_pkg::UPC_POPF;
          ade_pkg::MODE_POPB:  upc_nxt = ade_pkg::UPC_POPB;
          default:             upc_nxt = ade_pkg::UPC_IDLE;
        endcase
      end
    end else if (go) begin
      upc_nxt = cond_hit ? uw.tgt_t : uw.tgt_f;
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    ptr_nxt   = ptr_r;
    empty_nxt = empty_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    res       = '{status: ade_pkg::ST_DONE, data_value: 32'sd0, last_of_run: 1'b1};
    case (uw.op)
      ade_pkg::OP_PUSHF: begin
        res.status     = full_f ? ade_pkg::ST_FULL : ade_pkg::ST_DONE;
        res.data_value = full_f ? 32'sd0 : val_r;
        if (go && !full_f) begin
          wr_en = 1'b1;
          if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            wr_addr   = '0;
          end else begin
            head_nxt = head_r - ade_pkg::IDX_W'(1);
            wr_addr  = head_r - ade_pkg::IDX_W'(1);
          end
        end
      end
      ade_pkg::OP_PUSHB: begin
        res.status     = full_b ? ade_pkg::ST_FULL : ade_pkg::ST_DONE;
        res.data_value = full_b ? 32'sd0 : val_r;
        if (go && !full_b) begin
          wr_en = 1'b1;
          if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            wr_addr   = '0;
          end else begin
            tail_nxt = tail_r + ade_pkg::IDX_W'(1);
            wr_addr  = tail_r + ade_pkg::IDX_W'(1);
          end
        end
      end
      ade_pkg::OP_LDPTR: ptr_nxt = head_r;
      ade_pkg::OP_LIST: begin
        res.data_value  = rd_data_r;
        res.last_of_run = at_tail;
        if (go && !at_tail) ptr_nxt = ptr_r + ade_pkg::IDX_W'(1);
      end
      ade_pkg::OP_POPF: begin
        res.data_value = rd_data_r;
        if (go) begin
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            head_nxt = head_r + ade_pkg::IDX_W'(1);
          end
        end
      end
      ade_pkg::OP_POPB: begin
        res.data_value = rd_data_r;
        if (go) begin
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else begin
            tail_nxt = tail_r - ade_pkg::IDX_W'(1);
          end
        end
      end
      ade_pkg::OP_EMPTY: res.status = ade_pkg::ST_EMPTY;
      default: ;
    endcase
    // prefetch the entry the next step emits
    case (uw.rsel)
      ade_pkg::RS_TAIL: rd_addr = tail_r;
      ade_pkg::RS_PTR:  rd_addr = ptr_nxt;
      default:          rd_addr = head_r;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (uw.emit && go) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= ade_pkg::UPC_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      ptr_r       <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      ptr_r       <= ptr_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) val_r <= in_data.item_value;
    if (uw.emit && go) out_data_r <= res;
  end

  // element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) store_r[wr_addr] <= val_r;
    rd_data_r <= store_r[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ADE_ASSERT_NOW(a_empty_idx, empty_r, (head_r == '0) && (tail_r == '0))
  `ADE_ASSERT_NOW(a_order, !empty_r, head_r <= tail_r)
  `ADE_ASSERT_NOW(a_list_ptr, upc_r == ade_pkg::UPC_LISTE, (ptr_r >= head_r) && (ptr_r <= tail_r))
  `ADE_ASSERT_NEXT(a_busy, accept && (in_data.mode <= ade_pkg::MODE_POPB), in_stall)

endmodule
